/* rtl/smc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// smc_pkg
// Shared types, constants and helpers of the substring match counter.
// ----------------------------------------------------------------------------
package smc_pkg;

    localparam int PATTERN_MAX  = 32;                  // pattern bytes, window depth
    localparam int HIST_DEPTH   = PATTERN_MAX - 1;     // stored bytes before the newest
    localparam int WIN_IDX_BITS = $clog2(PATTERN_MAX);
    localparam int LEN_BITS     = 6;
    localparam int POS_BITS     = 32;
    localparam int COUNT_BITS   = 32;
    localparam int OFFSET_BITS  = 32;
    localparam int FIRST_BITS   = 34;
    localparam int WORD_BITS    = 64;
    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PATTERN_LENGTH = 3'd0,
        CFG_PATTERN_WORD_0 = 3'd1,
        CFG_PATTERN_WORD_1 = 3'd2,
        CFG_PATTERN_WORD_2 = 3'd3,
        CFG_PATTERN_WORD_3 = 3'd4,
        CFG_START_OFFSET   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [LEN_BITS-1:0]            len;      // effective length, 1..PATTERN_MAX
        logic [PATTERN_MAX-1:0][7:0]    pattern;  // byte 0 in element 0
        logic [OFFSET_BITS-1:0]         offset;
    } t_cfg;

    typedef struct packed {
        logic adv;    // the held beat is consumed this cycle
        logic last;   // that beat closes the region
    } t_step;

    typedef struct packed {
        logic [FIRST_BITS-1:0] first_position;
        logic [COUNT_BITS-1:0] match_count;
    } t_result;

    // Zero length reads as one, anything above the window as the window.
    function automatic logic [LEN_BITS-1:0] eff_len(input logic [LEN_BITS-1:0] raw);
        logic [LEN_BITS-1:0] res;
        if (raw == '0) begin
            res = LEN_BITS'(1);
        end else if (raw > LEN_BITS'(PATTERN_MAX)) begin
            res = LEN_BITS'(PATTERN_MAX);
        end else begin
            res = raw;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

/* rtl/substring_match_counter_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// substring_match_counter_unit
// Counts overlapping occurrences of a 1..32 byte pattern in a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel carries one text byte per beat (i_text_byte) with
//   i_end_of_text marking the last byte of a region. Output channel carries
//   one beat per region: the offset-adjusted start of the first match (all
//   ones if none) and the saturating count of overlapping matches.
//   Configure pattern length, four pattern words and the start offset
//   through the write port while the block is idle.
// Timing:
//   A byte is registered on acceptance and compared against the 32-byte
//   window in the following cycle; a region's result is registered as its
//   last byte leaves the input register. One byte per cycle is sustained,
//   bar a closing byte held by the stall; the window compare sets the limit.
// Stall:
//   While a result is held under i_out_stall, bytes without the end mark
//   keep flowing; a closing byte waits in the input register and the input
//   channel stalls until the output register frees up.
// Reset:
//   Synchronous, active low. Clears the handshakes, counters and config
//   (length 1, pattern and offset zero).
// ----------------------------------------------------------------------------
module substring_match_counter_unit
    import smc_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // input channel
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic [7:0]              i_text_byte,
    input  wire logic                    i_end_of_text,
    // output channel
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic signed [FIRST_BITS-1:0] o_first_position,
    output logic [COUNT_BITS-1:0]        o_match_count,
    // config write port
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [WORD_BITS-1:0]    i_cfg_data
);

    t_cfg    w_cfg;
    t_step   w_step;
    t_result w_result;
    logic    w_hit;
    logic    w_out_free;
    logic    w_emit;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // result register
    logic       r_out_valid;
    t_result    r_out;

    smc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // output register is free if empty or being drained this cycle
    assign w_out_free  = !r_out_valid || !i_out_stall;
    // only a closing beat needs room at the output
    assign w_step.adv  = r_in_valid && (!r_in_last || w_out_free);
    assign w_step.last = r_in_last;
    assign w_emit      = w_step.adv && r_in_last;
    assign o_in_stall  = r_in_valid && !w_step.adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (w_step.adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_text_byte;
            r_in_last <= i_end_of_text;
        end
    end

    smc_match u_match (
        .i_clk  (i_clk),
        .i_step (w_step),
        .i_byte (r_in_byte),
        .i_cfg  (w_cfg),
        .o_hit  (w_hit)
    );

    smc_tally u_tally (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_hit    (w_hit),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_first_position = signed'(r_out.first_position);
    assign o_match_count    = r_out.match_count;

`ifndef SYNTHESIS
    // input side only stalls when a beat is already held
    a_stall_needs_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with empty input register");

    // a new result beat comes only from a closing byte
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_emit))
        else $error("result beat without a closing byte");

    // no match means no first position
    a_none_means_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_match_count == '0) |-> (o_first_position == '1))
        else $error("first position set with zero matches");

    // a closing byte waits while the output is held
    a_last_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_last && r_out_valid && i_out_stall) |=> r_in_valid)
        else $error("closing byte dropped while output stalled");
`endif

endmodule
`default_nettype wire

/* rtl/smc_cfg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// smc_cfg
// Configuration register file: pattern length, pattern words, start offset.
// ----------------------------------------------------------------------------
module smc_cfg
    import smc_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [WORD_BITS-1:0]    i_cfg_data,
    output t_cfg                         o_cfg
);

    logic [LEN_BITS-1:0]    r_len;
    logic [WORD_BITS-1:0]   r_word0;
    logic [WORD_BITS-1:0]   r_word1;
    logic [WORD_BITS-1:0]   r_word2;
    logic [WORD_BITS-1:0]   r_word3;
    logic [OFFSET_BITS-1:0] r_offset;

    // length is stored already clamped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= LEN_BITS'(1);
            r_word0  <= '0;
            r_word1  <= '0;
            r_word2  <= '0;
            r_word3  <= '0;
            r_offset <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PATTERN_LENGTH: r_len    <= eff_len(i_cfg_data[LEN_BITS-1:0]);
                CFG_PATTERN_WORD_0: r_word0  <= i_cfg_data;
                CFG_PATTERN_WORD_1: r_word1  <= i_cfg_data;
                CFG_PATTERN_WORD_2: r_word2  <= i_cfg_data;
                CFG_PATTERN_WORD_3: r_word3  <= i_cfg_data;
                CFG_START_OFFSET:   r_offset <= i_cfg_data[OFFSET_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.len     = r_len;
    assign o_cfg.pattern = {r_word3, r_word2, r_word1, r_word0};
    assign o_cfg.offset  = r_offset;

endmodule
`default_nettype wire

/* rtl/smc_match.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// smc_match
// Byte history and parallel window compare against the configured pattern.
// ----------------------------------------------------------------------------
module smc_match
    import smc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire t_step      i_step,
    input  wire logic [7:0] i_byte,
    input  wire t_cfg       i_cfg,
    output logic            o_hit
);

    // r_hist[0] is the byte one beat ago; no reset, the tally gates on bytes seen
    logic [HIST_DEPTH-1:0][7:0]  r_hist;
    logic [PATTERN_MAX-1:0][7:0] w_win;
    logic [PATTERN_MAX-1:0]      w_ok;

    always_ff @(posedge i_clk) begin
        if (i_step.adv) begin
            r_hist <= {r_hist[HIST_DEPTH-2:0], i_byte};
        end
    end

    assign w_win = {r_hist, i_byte};

    // pattern byte k lines up with the byte (len-1-k) beats ago
    always_comb begin
        logic [LEN_BITS-1:0] ago;
        for (int k = 0; k < PATTERN_MAX; k++) begin
            ago = i_cfg.len - LEN_BITS'(k) - LEN_BITS'(1);
            if (LEN_BITS'(k) < i_cfg.len) begin
                w_ok[k] = (w_win[ago[WIN_IDX_BITS-1:0]] == i_cfg.pattern[k]);
            end else begin
                w_ok[k] = 1'b1;
            end
        end
    end

    assign o_hit = &w_ok;

endmodule
`default_nettype wire

/* rtl/smc_tally.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// smc_tally
// Per-region counters: bytes seen, match count, first match start.
// ----------------------------------------------------------------------------
module smc_tally
    import smc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_step i_step,
    input  wire logic  i_hit,
    input  wire t_cfg  i_cfg,
    output t_result    o_result
);

    logic [POS_BITS-1:0]   r_seen;
    logic [COUNT_BITS-1:0] r_total;
    logic [POS_BITS-1:0]   r_start;
    logic                  r_found;

    logic [POS_BITS-1:0]   n_seen;
    logic [COUNT_BITS-1:0] n_total;
    logic [POS_BITS-1:0]   n_start;
    logic                  n_found;
    logic                  w_match;
    logic [POS_BITS-1:0]   w_len;
    logic [OFFSET_BITS:0]  w_sum;

    assign w_len   = POS_BITS'(i_cfg.len);
    assign n_seen  = (r_seen == '1) ? r_seen : r_seen + POS_BITS'(1);
    // the whole match must lie inside the region
    assign w_match = i_hit && (n_seen >= w_len);
    assign n_found = r_found | w_match;
    assign n_start = (!r_found && w_match) ? n_seen - w_len : r_start;
    assign n_total = (w_match && r_total != '1) ? r_total + COUNT_BITS'(1) : r_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step.adv && i_step.last)) begin
            r_seen  <= '0;
            r_total <= '0;
            r_start <= '0;
            r_found <= 1'b0;
        end else if (i_step.adv) begin
            r_seen  <= n_seen;
            r_total <= n_total;
            r_start <= n_start;
            r_found <= n_found;
        end
    end

    assign w_sum = {1'b0, i_cfg.offset} + (OFFSET_BITS + 1)'(n_start);
    assign o_result.first_position = n_found ? FIRST_BITS'(w_sum) : '1;
    assign o_result.match_count    = n_total;

endmodule
`default_nettype wire
